// ===== rtl/chfl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the capture history likelihood block.
package chfl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IDX_W       = 10;
  localparam int PROB_W      = 32;
  localparam int NLL_W       = 63;
  localparam int MAG_W       = 38;
  localparam int CNT_W       = 16;
  localparam int SHIFT_W     = 5;

  localparam logic [PROB_W-1:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [31:0]       LN2_Q32 = 32'd2977044472;
  localparam logic [NLL_W-1:0]  NLL_MAX = {NLL_W{1'b1}};
  localparam logic [63:0]       LOG_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_LOAD_SURV = 2'd0,
    KIND_LOAD_DET  = 2'd1,
    KIND_OCCASION  = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_START,
    OP_MUL_D,
    OP_MUL_A,
    OP_MUL_P,
    OP_SUM,
    OP_NORM,
    OP_LOG,
    OP_MAG_LO,
    OP_MAG_HI,
    OP_HLS,
    OP_NLL,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_D,
    ST_MUL_A,
    ST_MUL_P,
    ST_SUM,
    ST_NORM,
    ST_LOG,
    ST_MAG_LO,
    ST_MAG_HI,
    ST_HLS,
    ST_NLL,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic u_zero;
    logic m_top;
    logic last;
    logic out_free;
  } dp_status_t;

  // Index within the table depth
  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(TABLE_DEPTH);
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [ADDR_W+IDX_W-1:0] ext;
    ext = (ADDR_W + IDX_W)'(idx);
    return ext[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/capture_history_forward_likelihood_top.sv =====
`timescale 1ns / 1ps
// Top level of the capture history forward likelihood block.
// Load and clear beats leave the input open. After an occasion beat the input stays
// closed while the block works through three multiply steps on one shared 32x32
// multiplier, the sum u, a normalise shift of one bit a cycle until the leading
// one is seen, the log-squaring loop that also steps both restoring dividers,
// and the log scaling and history sum. A zero u skips normalise, log and
// division. A last occasion adds the weighted result and then waits for the
// output register to be free. One item is worked on at a time; a finished
// result waits in the output register while the next beat is taken.
module capture_history_forward_likelihood_top
  import chfl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // table_index[9:0], table_value[41:10], survival_index[51:42],
  // detection_index[61:52], captured[62], first_occasion[63], history_count[79:64]
  input  logic [79:0]  s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // kind[1:0]
  input  logic         s_axis_tlast,  // last_occasion
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // history_nll[62:0], total_nll[125:63], zero[127:126]
  output logic [127:0] m_axis_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;
  kind_t      kind;
  logic [NLL_W-1:0] history_nll, total_nll;

  assign kind = kind_t'(s_axis_tuser);

  chfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (kind),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  chfl_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (kind),
    .table_index     (s_axis_tdata[9:0]),
    .table_value     (s_axis_tdata[41:10]),
    .survival_index  (s_axis_tdata[51:42]),
    .detection_index (s_axis_tdata[61:52]),
    .captured        (s_axis_tdata[62]),
    .first_occasion  (s_axis_tdata[63]),
    .last_occasion   (s_axis_tlast),
    .history_count   (s_axis_tdata[79:64]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .history_nll     (history_nll),
    .total_nll       (total_nll)
  );

  assign m_axis_tdata = {2'b00, total_nll, history_nll};

  // an occasion keeps the input closed while it is worked on
  a_occ_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_OCCASION)) |=> !s_axis_tready)
    else $error("input open straight after an occasion beat");

  // table loads leave the input open
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == KIND_LOAD_SURV || s_axis_tuser == KIND_LOAD_DET)) |=> s_axis_tready)
    else $error("input closed after a table load");

  // the running total already includes the history just emitted
  a_total_ge: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (total_nll >= history_nll))
    else $error("running total below history contribution");

endmodule

// ===== rtl/chfl_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
module chfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/chfl_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the occasion update: multiplies, normalise, log/divide loop, result.
module chfl_ctrl
  import chfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  kind_t      in_kind,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic [SHIFT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_kind)
            KIND_LOAD_SURV, KIND_LOAD_DET: cmd.op = OP_LOAD;
            KIND_CLEAR: cmd.op = OP_CLEAR;
            KIND_OCCASION: begin
              cmd.op     = OP_START;
              state_next = ST_MUL_D;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      ST_MUL_D: begin
        cmd.op     = OP_MUL_D;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.op     = OP_MUL_P;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op = OP_SUM;
        if (status.u_zero) begin
          state_next = status.last ? ST_NLL : ST_IDLE;
        end else begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (status.m_top) begin
          cnt_next   = '0;
          state_next = ST_LOG;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      ST_LOG: begin
        cmd.op   = OP_LOG;
        cnt_next = cnt + 1'b1;
        if (cnt == {SHIFT_W{1'b1}}) begin
          state_next = ST_MAG_LO;
        end
      end
      ST_MAG_LO: begin
        cmd.op     = OP_MAG_LO;
        state_next = ST_MAG_HI;
      end
      ST_MAG_HI: begin
        cmd.op     = OP_MAG_HI;
        state_next = ST_HLS;
      end
      ST_HLS: begin
        cmd.op     = OP_HLS;
        state_next = status.last ? ST_NLL : ST_IDLE;
      end
      ST_NLL: begin
        cmd.op     = OP_NLL;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/chfl_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: tables, state probabilities, shared multiplier, dividers, log and sums.
module chfl_dpath
  import chfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  kind_t              in_kind,
  input  logic [IDX_W-1:0]   table_index,
  input  logic [PROB_W-1:0]  table_value,
  input  logic [IDX_W-1:0]   survival_index,
  input  logic [IDX_W-1:0]   detection_index,
  input  logic               captured,
  input  logic               first_occasion,
  input  logic               last_occasion,
  input  logic [CNT_W-1:0]   history_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NLL_W-1:0]   history_nll,
  output logic [NLL_W-1:0]   total_nll
);

  logic [PROB_W-1:0] alive, dead, u, m, frac, acc;
  logic signed [63:0] hls;
  logic [NLL_W-1:0]  total, nll;
  logic [PROB_W:0]   ra, rd;
  logic [SHIFT_W-1:0] shift;
  logic [MAG_W-1:0]  mag;
  logic              cap, last, phi_ok, p_ok;
  logic [CNT_W-1:0]  count;

  logic [PROB_W-1:0] load_val, surv_rdata, det_rdata, phi, p;
  logic              load_ok;

  assign load_val = (table_value > ONE_Q31) ? ONE_Q31 : table_value;
  assign load_ok  = (cmd.op == OP_LOAD) && in_range(table_index);

  chfl_ram #(.WIDTH(PROB_W), .DEPTH(TABLE_DEPTH)) u_surv_ram (
    .clk   (clk),
    .we    (load_ok && (in_kind == KIND_LOAD_SURV)),
    .waddr (to_addr(table_index)),
    .wdata (load_val),
    .re    (cmd.op == OP_START),
    .raddr (to_addr(survival_index)),
    .rdata (surv_rdata)
  );

  chfl_ram #(.WIDTH(PROB_W), .DEPTH(TABLE_DEPTH)) u_det_ram (
    .clk   (clk),
    .we    (load_ok && (in_kind == KIND_LOAD_DET)),
    .waddr (to_addr(table_index)),
    .wdata (load_val),
    .re    (cmd.op == OP_START),
    .raddr (to_addr(detection_index)),
    .rdata (det_rdata)
  );

  assign phi = phi_ok ? surv_rdata : '0;
  assign p   = p_ok ? det_rdata : '0;

  // -ln(u) in log2 units: integer part from the normalise shift, fraction from squaring
  logic [63:0] neg;
  assign neg = {27'd0, shift, 32'd0} - {32'd0, frac};

  // Shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    mul_a = alive;
    mul_b = alive;
    case (cmd.op)
      OP_MUL_D:  begin mul_a = ONE_Q31 - phi; mul_b = alive; end
      OP_MUL_A:  begin mul_a = phi;           mul_b = alive; end
      OP_MUL_P:  begin mul_a = alive;         mul_b = cap ? p : (ONE_Q31 - p); end
      OP_LOG:    begin mul_a = m;             mul_b = m; end
      OP_MAG_LO: begin mul_a = neg[31:0];     mul_b = LN2_Q32; end
      OP_MAG_HI: begin mul_a = neg[63:32];    mul_b = LN2_Q32; end
      default:   begin mul_a = alive;         mul_b = alive; end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  logic [PROB_W:0] u_sum, sq;
  assign u_sum = {1'b0, alive} + {1'b0, dead};
  assign sq    = prod[63:31];

  // One restoring division step for each of the two quotients
  logic            ge_a, ge_d;
  logic [PROB_W:0] ra_sub, rd_sub;
  assign ge_a   = ra >= {1'b0, u};
  assign ge_d   = rd >= {1'b0, u};
  assign ra_sub = ge_a ? (ra - {1'b0, u}) : ra;
  assign rd_sub = ge_d ? (rd - {1'b0, u}) : rd;

  logic [64:0] hls_diff;
  assign hls_diff = {hls[63], hls} - {27'd0, mag};

  logic [63:0] hmag;
  logic [79:0] nprod;
  assign hmag  = 64'd0 - hls;
  assign nprod = 80'(hmag) * 80'(count);

  logic [63:0] tot_sum;
  logic [NLL_W-1:0] tot_new;
  assign tot_sum = {1'b0, total} + {1'b0, nll};
  assign tot_new = (tot_sum > {1'b0, NLL_MAX}) ? NLL_MAX : tot_sum[NLL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      alive     <= ONE_Q31;
      dead      <= '0;
      hls       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: total <= '0;
        OP_START: begin
          cap    <= captured;
          last   <= last_occasion;
          count  <= history_count;
          phi_ok <= in_range(survival_index);
          p_ok   <= in_range(detection_index);
          if (first_occasion) begin
            alive <= ONE_Q31;
            dead  <= '0;
            hls   <= '0;
          end
        end
        OP_MUL_D: dead  <= dead + prod[62:31];
        OP_MUL_A: alive <= prod[62:31];
        OP_MUL_P: begin
          alive <= prod[62:31];
          if (cap) begin
            dead <= '0;
          end
        end
        OP_SUM: begin
          if (u_sum == '0) begin
            alive <= '0;
            dead  <= '0;
            hls   <= LOG_MIN;
          end else begin
            u     <= u_sum[PROB_W-1:0];
            m     <= u_sum[PROB_W-1:0];
            shift <= '0;
            frac  <= '0;
            ra    <= {1'b0, alive};
            rd    <= {1'b0, dead};
          end
        end
        OP_NORM: begin
          m     <= {m[PROB_W-2:0], 1'b0};
          shift <= shift + 1'b1;
        end
        OP_LOG: begin
          if (sq[PROB_W]) begin
            m    <= sq[PROB_W:1];
            frac <= {frac[PROB_W-2:0], 1'b1};
          end else begin
            m    <= sq[PROB_W-1:0];
            frac <= {frac[PROB_W-2:0], 1'b0};
          end
          // quotients shift into the probability registers
          ra    <= {ra_sub[PROB_W-1:0], 1'b0};
          rd    <= {rd_sub[PROB_W-1:0], 1'b0};
          alive <= {alive[PROB_W-2:0], ge_a};
          dead  <= {dead[PROB_W-2:0], ge_d};
        end
        OP_MAG_LO: acc <= prod[63:32];
        OP_MAG_HI: mag <= prod[MAG_W-1:0] + MAG_W'(acc);
        OP_HLS: begin
          if (hls_diff[64] && !hls_diff[63]) begin
            hls <= LOG_MIN;
          end else begin
            hls <= hls_diff[63:0];
          end
        end
        OP_NLL: begin
          if (count == '0) begin
            nll <= '0;
          end else if (nprod[79:NLL_W] != '0) begin
            nll <= NLL_MAX;
          end else begin
            nll <= nprod[NLL_W-1:0];
          end
        end
        OP_EMIT: begin
          total       <= tot_new;
          history_nll <= nll;
          total_nll   <= tot_new;
        end
        default: ;
      endcase
    end
  end

  assign status.u_zero   = (u_sum == '0);
  assign status.m_top    = m[PROB_W-1];
  assign status.last     = last;
  assign status.out_free = !out_valid || out_ready;

endmodule
